FILE: src/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // Fixed field widths
    localparam int OW     = 5;   // order field
    localparam int OFS_W  = 16;  // byte offset / request size
    localparam int HDR_W  = 8;   // header byte count
    localparam int CFG_W  = 8;   // widest configuration register
    localparam int CFG_IW = 1;   // configuration index

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_POOL_ORDER   = 1'b0;
    localparam logic [CFG_IW-1:0] REG_HEADER_BYTES = 1'b1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_OOM  = 1'b1;

    typedef struct packed {
        logic             op;
        logic [OFS_W-1:0] request_bytes;
        logic [OFS_W-1:0] block_offset;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [OFS_W-1:0] granted_offset;
        logic [OW-1:0]    granted_order;
    } t_out;

    // Command handed from the front end to the sequencer
    typedef struct packed {
        logic             op;
        logic [OW-1:0]    order;
        logic [OFS_W-1:0] offset;
    } t_cmd;

    // Per-granule block metadata
    typedef struct packed {
        logic          free;
        logic [OW-1:0] order;
    } t_meta;

endpackage

FILE: src/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl #(
    parameter int POOL_ORDER_MAX = 16,
    parameter int GRANULE_ORDER  = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [4:0]    i_top,
    input  logic          i_reinit,
    input  logic          i_start,
    input  bba_pkg::t_cmd i_cmd,
    output logic          o_busy,
    output logic          o_res_v,
    output bba_pkg::t_out o_res
);
    import bba_pkg::*;

    localparam int GW   = POOL_ORDER_MAX - GRANULE_ORDER;
    localparam int GCNT = 1 << GW;
    localparam int LW   = GW + 1;
    localparam int HN   = POOL_ORDER_MAX + 1;
    localparam int HW   = $clog2(HN);
    localparam logic [LW-1:0] NIL = LW'(GCNT);
    localparam logic [OW-1:0] GO  = OW'(GRANULE_ORDER);

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b0000_0000_0001,
        S_IDLE    = 12'b0000_0000_0010,
        S_A_SRCH  = 12'b0000_0000_0100,
        S_A_UNL   = 12'b0000_0000_1000,
        S_A_SPL   = 12'b0000_0001_0000,
        S_A_SPL2  = 12'b0000_0010_0000,
        S_F_K     = 12'b0000_0100_0000,
        S_F_CHK   = 12'b0000_1000_0000,
        S_F_MRG   = 12'b0001_0000_0000,
        S_F_MCHK  = 12'b0010_0000_0000,
        S_F_PUSH  = 12'b0100_0000_0000,
        S_F_PUSH2 = 12'b1000_0000_0000
    } t_state;

    function automatic logic [GW-1:0] unit_of(input logic [OW-1:0] o);
        unit_of = GW'(1) << (o - GO);
    endfunction

    function automatic logic [OFS_W-1:0] offs_of(input logic [GW-1:0] g);
        logic [POOL_ORDER_MAX-1:0] t;
        t = {g, {GRANULE_ORDER{1'b0}}};
        offs_of = OFS_W'(t);
    endfunction

    t_state        r_state, n_state;
    logic [OW-1:0] r_i, n_i, r_n, n_n, r_k, n_k, r_gord, n_gord;
    logic [GW-1:0] r_g, n_g, r_b, n_b, r_clr, n_clr;
    logic          r_res_v, n_res_v;
    t_out          r_res, n_res;
    logic [LW-1:0] r_head [HN];

    // memory ports
    logic          meta_we;
    logic [GW-1:0] meta_wa, meta_ra;
    t_meta         meta_wd, meta_rd;
    logic          next_we, prev_we;
    logic [GW-1:0] next_wa, prev_wa, link_ra;
    logic [LW-1:0] next_wd, prev_wd, next_rd, prev_rd;

    // list head file controls
    logic          head_init, head_we;
    logic [HW-1:0] head_wi;
    logic [LW-1:0] head_wd;

    // scratch values
    logic [LW-1:0]             hsel;
    logic [OW-1:0]             kcl, i1;
    logic [GW-1:0]             gk, bb;
    logic [POOL_ORDER_MAX-1:0] off_ext;
    logic [GW-1:0]             tmask;

    bba_ram #(.W(OW + 1), .D(GCNT)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(meta_ra), .o_rdata(meta_rd)
    );
    bba_ram #(.W(LW), .D(GCNT)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(link_ra), .o_rdata(next_rd)
    );
    bba_ram #(.W(LW), .D(GCNT)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(link_ra), .o_rdata(prev_rd)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_n     = r_n;
        n_k     = r_k;
        n_gord  = r_gord;
        n_g     = r_g;
        n_b     = r_b;
        n_clr   = r_clr;
        n_res_v = 1'b0;
        n_res   = r_res;
        meta_we = 1'b0;
        meta_wa = r_g;
        meta_wd = '0;
        meta_ra = r_g;
        link_ra = r_g;
        next_we = 1'b0;
        next_wa = r_g;
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = r_g;
        prev_wd = NIL;
        head_init = 1'b0;
        head_we   = 1'b0;
        head_wi   = r_k[HW-1:0];
        head_wd   = NIL;
        hsel    = r_head[r_i[HW-1:0]];
        kcl     = (meta_rd.order < GO) ? GO :
                  (meta_rd.order > i_top) ? i_top : meta_rd.order;
        i1      = r_i - OW'(1);
        gk      = r_g & ~(unit_of(kcl) - GW'(1));
        bb      = r_g ^ unit_of(r_k);
        off_ext = POOL_ORDER_MAX'(i_cmd.offset);
        tmask   = unit_of(i_top) - GW'(1);

        unique case (r_state)
            S_CLEAR: begin
                // sweep the metadata, seed the single top block
                head_init = 1'b1;
                meta_we   = 1'b1;
                meta_wa   = r_clr;
                if (r_clr == '0) begin
                    meta_wd = '{free: 1'b1, order: i_top};
                    next_we = 1'b1;
                    next_wa = '0;
                    prev_we = 1'b1;
                    prev_wa = '0;
                end
                n_clr = r_clr + GW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd.op == OP_ALLOC) begin
                        n_n     = i_cmd.order;
                        n_i     = i_cmd.order;
                        n_state = S_A_SRCH;
                    end else begin
                        n_g     = off_ext[POOL_ORDER_MAX-1:GRANULE_ORDER] & tmask;
                        meta_ra = n_g;
                        n_state = S_F_K;
                    end
                end
            end
            S_A_SRCH: begin
                // walk up the orders to the first non-empty list
                if (r_i > i_top) begin
                    n_res_v = 1'b1;
                    n_res   = '{status: ST_OOM, granted_offset: '0, granted_order: '0};
                    n_state = S_IDLE;
                end else if (!hsel[GW]) begin
                    n_g     = hsel[GW-1:0];
                    link_ra = hsel[GW-1:0];
                    n_state = S_A_UNL;
                end else begin
                    n_i = r_i + OW'(1);
                end
            end
            S_A_UNL: begin
                // unlink the head block from its list
                head_wi = r_i[HW-1:0];
                if (!prev_rd[GW]) begin
                    next_we = 1'b1;
                    next_wa = prev_rd[GW-1:0];
                    next_wd = next_rd;
                end else begin
                    head_we = 1'b1;
                    head_wd = next_rd;
                end
                if (!next_rd[GW]) begin
                    prev_we = 1'b1;
                    prev_wa = next_rd[GW-1:0];
                    prev_wd = prev_rd;
                end
                n_state = S_A_SPL;
            end
            S_A_SPL: begin
                if (r_i > r_n) begin
                    // split: push the upper buddy onto the next lower list
                    n_b     = r_g | unit_of(i1);
                    n_i     = i1;
                    meta_we = 1'b1;
                    meta_wa = n_b;
                    meta_wd = '{free: 1'b1, order: i1};
                    head_wi = i1[HW-1:0];
                    hsel    = r_head[i1[HW-1:0]];
                    next_we = 1'b1;
                    next_wa = n_b;
                    next_wd = hsel;
                    if (!hsel[GW]) begin
                        prev_we = 1'b1;
                        prev_wa = hsel[GW-1:0];
                        prev_wd = {1'b0, n_b};
                    end
                    head_we = 1'b1;
                    head_wd = {1'b0, n_b};
                    n_state = S_A_SPL2;
                end else begin
                    meta_we = 1'b1;
                    meta_wa = r_g;
                    meta_wd = '{free: 1'b0, order: r_n};
                    n_res_v = 1'b1;
                    n_res   = '{status: ST_DONE, granted_offset: offs_of(r_g),
                                granted_order: r_n};
                    n_state = S_IDLE;
                end
            end
            S_A_SPL2: begin
                prev_we = 1'b1;
                prev_wa = r_b;
                n_state = S_A_SPL;
            end
            S_F_K: begin
                // clamp the stored order and align the block start
                n_k     = kcl;
                n_g     = gk;
                meta_ra = gk;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (meta_rd.free) begin
                    n_res_v = 1'b1;
                    n_res   = '{status: ST_DONE, granted_offset: offs_of(r_g),
                                granted_order: meta_rd.order};
                    n_state = S_IDLE;
                end else begin
                    n_gord  = meta_rd.order;
                    n_state = S_F_MRG;
                end
            end
            S_F_MRG: begin
                if (r_k < i_top) begin
                    n_b     = bb;
                    meta_ra = bb;
                    link_ra = bb;
                    n_state = S_F_MCHK;
                end else begin
                    n_state = S_F_PUSH;
                end
            end
            S_F_MCHK: begin
                if (meta_rd.free && meta_rd.order == r_k) begin
                    // absorb the buddy: unlink it, clear the upper start
                    if (!prev_rd[GW]) begin
                        next_we = 1'b1;
                        next_wa = prev_rd[GW-1:0];
                        next_wd = next_rd;
                    end else begin
                        head_we = 1'b1;
                        head_wd = next_rd;
                    end
                    if (!next_rd[GW]) begin
                        prev_we = 1'b1;
                        prev_wa = next_rd[GW-1:0];
                        prev_wd = prev_rd;
                    end
                    meta_we = 1'b1;
                    if (r_b > r_g) begin
                        meta_wa = r_b;
                        meta_wd = '{free: 1'b0, order: r_k};
                    end else begin
                        meta_wa = r_g;
                        meta_wd = '{free: 1'b0, order: r_gord};
                        n_g     = r_b;
                        n_gord  = r_k;
                    end
                    n_k     = r_k + OW'(1);
                    n_state = S_F_MRG;
                end else begin
                    n_state = S_F_PUSH;
                end
            end
            S_F_PUSH: begin
                meta_we = 1'b1;
                meta_wa = r_g;
                meta_wd = '{free: 1'b1, order: r_k};
                hsel    = r_head[r_k[HW-1:0]];
                next_we = 1'b1;
                next_wa = r_g;
                next_wd = hsel;
                if (!hsel[GW]) begin
                    prev_we = 1'b1;
                    prev_wa = hsel[GW-1:0];
                    prev_wd = {1'b0, r_g};
                end
                head_we = 1'b1;
                head_wd = {1'b0, r_g};
                n_state = S_F_PUSH2;
            end
            S_F_PUSH2: begin
                prev_we = 1'b1;
                prev_wa = r_g;
                n_res_v = 1'b1;
                n_res   = '{status: ST_DONE, granted_offset: offs_of(r_g),
                            granted_order: r_k};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // a pool resize restarts the clearing sweep
        if (i_reinit) begin
            n_state = S_CLEAR;
            n_clr   = '0;
            n_res_v = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_res_v <= n_res_v;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_n    <= n_n;
        r_k    <= n_k;
        r_gord <= n_gord;
        r_g    <= n_g;
        r_b    <= n_b;
        r_res  <= n_res;
    end

    // list head file
    always_ff @(posedge i_clk) begin
        if (head_init) begin
            for (int h = 0; h < HN; h++) begin
                r_head[h] <= (HW'(h) == i_top[HW-1:0] && OW'(h) == i_top) ? '0 : NIL;
            end
        end else if (head_we) begin
            r_head[head_wi] <= head_wd;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_res_v = r_res_v;
    assign o_res   = r_res;

`ifndef SYNTH
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_v |-> r_state == S_IDLE)
        else $error("result beat without return to idle");
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_v && r_res.status == ST_OOM |->
            r_res.granted_offset == '0 && r_res.granted_order == '0)
        else $error("out-of-memory beat carries a payload");
    a_order_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_v && r_res.status == ST_DONE |-> r_res.granted_order <= i_top)
        else $error("granted order above pool order");
    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR && !i_reinit |=> r_state == S_CLEAR || r_state == S_IDLE)
        else $error("clearing sweep left early");
`endif
endmodule

FILE: src/buddy_block_allocator_core.sv
`timescale 1ns / 1ps

// Binary buddy allocator with one LIFO free list per order. Pulse start while
// busy is low to issue an allocate or free; exactly one result beat follows on
// o_result_valid, which the receiver cannot stall. Block state lives in three
// one-port-read RAMs (metadata, next and previous links), and every step is a
// read followed by a write-back. Busy stays high from the accepting edge until
// the result beat, so a new command is taken only after the last one's result.
// Allocate searches upward from the rounded request order n to the pool order
// for a non-empty list, unlinks its head and splits it down to order n; out of
// memory is answered when no list up to the pool order holds a block. Free
// merges with free buddies of equal order up to the pool order and pushes the
// result; a double free reports the free block unchanged. After reset and after
// every pool_order write the metadata RAM is swept once over all
// 2^(POOL_ORDER_MAX-GRANULE_ORDER) granules (4096 by default), with busy high.
module buddy_block_allocator_core #(
    parameter int POOL_ORDER_MAX = 16,
    parameter int GRANULE_ORDER  = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bba_pkg::t_in                i_item,
    output logic                        o_result_valid,
    output bba_pkg::t_out               o_result,
    input  logic                        i_cfg_we,
    input  logic [bba_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [bba_pkg::CFG_W-1:0]   i_cfg_data
);
    import bba_pkg::*;

    localparam logic [OW-1:0] GO = OW'(GRANULE_ORDER);
    localparam logic [OW-1:0] PM = OW'(POOL_ORDER_MAX);

    logic [OW-1:0]    r_pool;
    logic [HDR_W-1:0] r_hdr;
    logic [OW-1:0]    top;
    logic             reinit;
    logic [OFS_W:0]   total, tm1;
    logic [OW-1:0]    fl, ord;
    t_cmd             cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= OW'(16);
            r_hdr  <= HDR_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POOL_ORDER:   r_pool <= i_cfg_data[OW-1:0];
                REG_HEADER_BYTES: r_hdr  <= i_cfg_data[HDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign reinit = i_cfg_we && (i_cfg_idx == REG_POOL_ORDER);
    assign top    = (r_pool < GO) ? GO : (r_pool > PM) ? PM : r_pool;

    // round request plus header up to a power-of-two order
    always_comb begin
        total = {1'b0, i_item.request_bytes} + (OFS_W + 1)'(r_hdr);
        tm1   = total - (OFS_W + 1)'(1);
        fl    = '0;
        for (int b = 0; b <= OFS_W; b++) begin
            if (tm1[b]) begin
                fl = OW'(b);
            end
        end
        ord = (total <= (OFS_W + 1)'(1)) ? '0 : fl + OW'(1);
        if (ord < GO) begin
            ord = GO;
        end
        cmd = '{op: i_item.op, order: ord, offset: i_item.block_offset};
    end

    bba_ctrl #(
        .POOL_ORDER_MAX(POOL_ORDER_MAX),
        .GRANULE_ORDER (GRANULE_ORDER)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_top   (top),
        .i_reinit(reinit),
        .i_start (start),
        .i_cmd   (cmd),
        .o_busy  (busy),
        .o_res_v (o_result_valid),
        .o_res   (o_result)
    );
endmodule

FILE: verif/buddy_alloc_monitor.sv
`timescale 1ns / 1ps

module buddy_alloc_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  bba_pkg::t_in                i_item,
    input  logic                        i_result_valid,
    input  bba_pkg::t_out               i_result,
    input  logic                        i_cfg_we,
    input  logic [bba_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [bba_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bba_pkg::*;

    localparam int POOL_MAX  = 16;
    localparam int GRAN      = 4;
    localparam int GRAN_CNT  = 1 << (POOL_MAX - GRAN);
    localparam int LINK_NULL = GRAN_CNT;

    // Shadow allocator state
    bit       blk_free  [GRAN_CNT];
    bit [4:0] blk_order [GRAN_CNT];
    int       link_next [GRAN_CNT];
    int       link_prev [GRAN_CNT];
    int       order_head[POOL_MAX+1];
    int       pool_order_reg;
    int       header_reg;

    t_out grant_q[$];

    function automatic int top_order();
        if (pool_order_reg < GRAN) return GRAN;
        if (pool_order_reg > POOL_MAX) return POOL_MAX;
        return pool_order_reg;
    endfunction

    task automatic rebuild_pool();
        int t;
        t = top_order();
        for (int j = 0; j < GRAN_CNT; j++) begin
            blk_free[j]  = 1'b0;
            blk_order[j] = '0;
            link_next[j] = 0;
            link_prev[j] = 0;
        end
        for (int j = 0; j <= POOL_MAX; j++) order_head[j] = LINK_NULL;
        blk_free[0]   = 1'b1;
        blk_order[0]  = t[4:0];
        link_next[0]  = LINK_NULL;
        link_prev[0]  = LINK_NULL;
        order_head[t] = 0;
    endtask

    task automatic list_push(int k, int g);
        int h;
        h = order_head[k];
        link_prev[g] = LINK_NULL;
        link_next[g] = h;
        if (h < GRAN_CNT) link_prev[h] = g;
        order_head[k] = g;
    endtask

    task automatic list_unlink(int k, int g);
        int p;
        int n;
        p = link_prev[g];
        n = link_next[g];
        if (p < GRAN_CNT) link_next[p] = n;
        else order_head[k] = n;
        if (n < GRAN_CNT) link_prev[n] = p;
    endtask

    // Compute the grant for one command and update the shadow state
    task automatic predict_grant(input t_in it, output t_out r);
        int t;
        int g;
        int k;
        int n;
        int i;
        int b;
        longint total;
        t = top_order();
        r = '0;
        if (it.op == OP_ALLOC) begin
            total = longint'(it.request_bytes) + header_reg;
            n = 0;
            while (n < 40 && (64'd1 << n) < total) n++;
            if (n < GRAN) n = GRAN;
            i = n;
            while (i <= t && order_head[i] >= GRAN_CNT) i++;
            if (i > t) begin
                r.status = ST_OOM;
                return;
            end
            g = order_head[i];
            list_unlink(i, g);
            // split down, pushing each upper half
            while (i > n) begin
                i--;
                b = g + (1 << (i - GRAN));
                if (b < GRAN_CNT) begin
                    blk_order[b] = i[4:0];
                    blk_free[b]  = 1'b1;
                    list_push(i, b);
                end
            end
            blk_free[g]  = 1'b0;
            blk_order[g] = n[4:0];
            r.status         = ST_DONE;
            r.granted_offset = 16'(g << GRAN);
            r.granted_order  = n[4:0];
            return;
        end
        g = int'(it.block_offset) >> GRAN;
        g &= (1 << (t - GRAN)) - 1;
        k = blk_order[g];
        if (k < GRAN) k = GRAN;
        if (k > t) k = t;
        g &= ~((1 << (k - GRAN)) - 1);
        r.status = ST_DONE;
        // already free: report it unchanged
        if (blk_free[g]) begin
            r.granted_offset = 16'(g << GRAN);
            r.granted_order  = blk_order[g];
            return;
        end
        // merge with free buddies of equal order
        while (k < t) begin
            b = g ^ (1 << (k - GRAN));
            if (b >= GRAN_CNT || !blk_free[b] || blk_order[b] != k) break;
            list_unlink(k, b);
            blk_free[(b > g) ? b : g] = 1'b0;
            if (b < g) g = b;
            k++;
        end
        blk_order[g] = k[4:0];
        blk_free[g]  = 1'b1;
        list_push(k, g);
        r.granted_offset = 16'(g << GRAN);
        r.granted_order  = k[4:0];
    endtask

    assign o_pending = grant_q.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        t_out got_r;
        if (!i_rst_n) begin
            o_fail_count   = 0;
            pool_order_reg = 16;
            header_reg     = 16;
            rebuild_pool();
            grant_q.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_POOL_ORDER) begin
                    pool_order_reg = int'(i_cfg_data[4:0]);
                    rebuild_pool();
                end else if (i_cfg_idx == REG_HEADER_BYTES) begin
                    header_reg = int'(i_cfg_data);
                end
            end
            // compare each result beat with the oldest grant
            if (i_result_valid) begin
                got_r = i_result;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $realtime, got_r);
                    o_fail_count++;
                end else begin
                    exp_r = grant_q.pop_front();
                    if (got_r.status !== exp_r.status) begin
                        $display("%0t: status expected %h actual %h",
                                 $realtime, exp_r.status, got_r.status);
                        o_fail_count++;
                    end
                    if (got_r.granted_offset !== exp_r.granted_offset) begin
                        $display("%0t: granted_offset expected %h actual %h",
                                 $realtime, exp_r.granted_offset, got_r.granted_offset);
                        o_fail_count++;
                    end
                    if (got_r.granted_order !== exp_r.granted_order) begin
                        $display("%0t: granted_order expected %h actual %h",
                                 $realtime, exp_r.granted_order, got_r.granted_order);
                        o_fail_count++;
                    end
                end
            end
            // predict on each accepted command beat
            if (i_start && !i_busy) begin
                predict_grant(i_item, exp_r);
                grant_q.push_back(exp_r);
            end
        end
    end

endmodule

FILE: verif/buddy_block_allocator_core_test.sv
`timescale 1ns / 1ps

module buddy_block_allocator_core_test;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 1750;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in                 i_item;
    logic                o_result_valid;
    t_out                o_result;
    logic                i_cfg_we;
    logic [CFG_IW-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    int                  fail_count;
    int                  pending;
    int                  cycles;

    // Stimulus bookkeeping
    logic       issued_op[$];
    logic [15:0] live_blocks[$];
    logic [15:0] last_free_grant;
    int         pool_eff;
    int         gap_pct;

    buddy_block_allocator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    buddy_alloc_monitor u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Harvest granted blocks so frees target live allocations
    always @(posedge i_clk) begin
        logic op;
        if (i_rst_n && o_result_valid && issued_op.size() != 0) begin
            op = issued_op.pop_front();
            if (op == OP_ALLOC && o_result.status == ST_DONE)
                live_blocks.push_back(o_result.granted_offset);
            if (op == OP_FREE)
                last_free_grant = o_result.granted_offset;
        end
    end

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Present one command beat and hold it until accepted
    task automatic send_beat(t_in it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        issued_op.push_back(it.op);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (issued_op.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_alloc(int bytes);
        t_in it;
        it.op            = OP_ALLOC;
        it.request_bytes = 16'(bytes);
        it.block_offset  = 16'($urandom);
        send_beat(it);
    endtask

    // Free a block, optionally with junk below the granule and above the pool
    task automatic send_free(logic [15:0] off, bit junk);
        t_in it;
        it.op            = OP_FREE;
        it.request_bytes = 16'($urandom);
        it.block_offset  = off;
        if (junk) begin
            it.block_offset[3:0] = 4'($urandom);
            if (pool_eff < 16)
                it.block_offset = it.block_offset | 16'(($urandom << pool_eff));
        end
        send_beat(it);
    endtask

    task automatic free_random_live();
        int idx;
        logic [15:0] off;
        idx = $urandom_range(0, live_blocks.size() - 1);
        off = live_blocks[idx];
        live_blocks.delete(idx);
        send_free(off, $urandom_range(0, 3) == 0);
    endtask

    // Free, then free the merged block again once it is reported
    task automatic free_twice();
        free_random_live();
        wait_drained();
        send_free(last_free_grant, 1'b0);
    endtask

    // Write both registers while idle; a pool write rebuilds the pool
    task automatic set_config(int po, int hdr);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_POOL_ORDER;
        i_cfg_data <= CFG_W'(po);
        @(posedge i_clk);
        i_cfg_idx  <= REG_HEADER_BYTES;
        i_cfg_data <= CFG_W'(hdr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        live_blocks.delete();
        pool_eff = (po < 4) ? 4 : ((po > 16) ? 16 : po);
    endtask

    function automatic int pick_size();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
        return $urandom_range(0, 1 << $urandom_range(0, 10));
    endfunction

    initial begin
        int po_list[6];
        int hdr_list[6];
        int chunk;
        po_list  = '{16, 4, 31, 7, 0, 12};
        hdr_list = '{0, 255, 16, 3, 0, 200};
        pool_eff   = 16;
        gap_pct    = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, whole pool, out of memory, double free
        send_alloc(65520);
        send_alloc(0);
        wait_drained();
        free_twice();
        send_alloc(65535);
        send_alloc(0);
        send_alloc(1);
        send_alloc(100);
        send_alloc(5000);
        send_alloc(40000);
        wait_drained();
        while (live_blocks.size() != 0) free_random_live();
        wait_drained();
        set_config(4, 0);
        send_alloc(16);
        send_alloc(17);
        send_alloc(0);
        wait_drained();
        free_twice();
        set_config(16, 255);
        send_alloc(65281);
        send_alloc(65280);
        wait_drained();
        free_random_live();
        wait_drained();

        // Random phases over several register settings
        chunk = RAND_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++) begin
            set_config(po_list[ph], hdr_list[ph]);
            gap_pct = (ph < 2) ? 27 : ((ph < 4) ? 67 : 0);
            for (int n = 0; n < chunk; n++) begin
                if ($urandom_range(0, 99) < gap_pct)
                    idle_cycles($urandom_range(1, 6));
                if (live_blocks.size() != 0 && $urandom_range(0, 39) == 0)
                    free_twice();
                else if (live_blocks.size() != 0 && $urandom_range(0, 99) < 45)
                    free_random_live();
                else
                    send_alloc(pick_size());
            end
        end

        wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/buddy_block_allocator_core.sv
verif/buddy_alloc_monitor.sv
verif/buddy_block_allocator_core_test.sv
